### rtl/wpcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpcm_pkg: shared types and constants
// Opcodes, controller/datapath command and status groups, fixed constants.
// ----------------------------------------------------------------------------
package wpcm_pkg;

    localparam int unsigned TIME_W    = 64;
    localparam int unsigned TOTAL_W   = 64;
    localparam int unsigned WIN_W     = 32;
    localparam int unsigned RAW_W     = 16;
    localparam int unsigned TALLY_W   = 32;
    localparam int unsigned SPAN_W    = 42;
    localparam int unsigned WIDEN_SH  = 15;
    localparam int unsigned STEP_W    = 7;

    localparam logic [9:0]        MS_TO_US   = 10'd1000;
    localparam logic [STEP_W-1:0] MUL_LAST   = 7'd63;
    localparam logic [STEP_W-1:0] DIV_LAST   = 7'd127;

    typedef enum logic [2:0] {
        OP_HIGH  = 3'd0,
        OP_LOW   = 3'd1,
        OP_SNAP  = 3'd2,
        OP_QUERY = 3'd3,
        OP_CLEAR = 3'd4
    } t_opcode;

    typedef struct packed {
        logic accept;
        logic calc_start;
        logic clamp;
        logic walk;
        logic prep;
        logic mul;
        logic div;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_ok;
        logic hit;
        logic first;
        logic walk_end;
        logic t_equal;
        logic mul_done;
        logic div_done;
    } t_dp_stat;

endpackage

### rtl/wpcm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpcm_ctrl: query sequencer
// One-hot state machine stepping the datapath through a query.
// ----------------------------------------------------------------------------
module wpcm_ctrl import wpcm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [2:0] i_opcode,
    input  t_dp_stat   i_stat,
    output logic       busy,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_OLD   = 8'b0000_0010,
        S_CLAMP = 8'b0000_0100,
        S_WALK  = 8'b0000_1000,
        S_PREP  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && (t_opcode'(i_opcode) == OP_QUERY) && i_stat.fill_ok) begin
                    n_state = S_OLD;
                end
            end
            S_OLD:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_WALK;
            S_WALK: begin
                if (i_stat.hit) begin
                    n_state = i_stat.first ? S_FIN : S_PREP;
                end else if (i_stat.walk_end) begin
                    n_state = S_FIN;
                end
            end
            S_PREP:  n_state = i_stat.t_equal ? S_FIN : S_MUL;
            S_MUL:   n_state = i_stat.mul_done ? S_DIV : S_MUL;
            S_DIV:   n_state = i_stat.div_done ? S_FIN : S_DIV;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_cmd.accept     = start && (r_state == S_IDLE);
    assign o_cmd.calc_start = (r_state == S_OLD);
    assign o_cmd.clamp      = (r_state == S_CLAMP);
    assign o_cmd.walk       = (r_state == S_WALK);
    assign o_cmd.prep       = (r_state == S_PREP);
    assign o_cmd.mul        = (r_state == S_MUL);
    assign o_cmd.div        = (r_state == S_DIV);
    assign o_cmd.fin        = (r_state == S_FIN);

endmodule

### rtl/wpcm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpcm_dp: ring, tally and query arithmetic
// Snapshot ring memories, walk pointers, shift-add multiply, restoring divide.
// ----------------------------------------------------------------------------
module wpcm_dp import wpcm_pkg::*; #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [2:0]                i_opcode,
    input  logic [TIME_W-1:0]         i_time_us,
    input  logic signed [RAW_W-1:0]   i_raw_count,
    input  logic [WIN_W-1:0]          i_window_ms,
    output t_dp_stat                  o_stat,
    output logic                      o_valid,
    output logic [TOTAL_W-1:0]        o_pulse_count,
    output logic                      o_enough_data
);

    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned FW = $clog2(RING_DEPTH + 1);
    localparam int unsigned XW = AW + 1;
    localparam logic [AW-1:0] SLOT_MAX = AW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(RING_DEPTH);

    logic [TIME_W-1:0]  mem_time  [RING_DEPTH];
    logic [TOTAL_W-1:0] mem_total [RING_DEPTH];

    logic [AW-1:0]      r_wslot, r_last, r_oldest, r_idx;
    logic [FW-1:0]      r_fill, r_i;
    logic [TALLY_W-1:0] r_tally;
    logic [TIME_W-1:0]  r_now, r_start, r_rd_time, r_t1, r_t2, r_den;
    logic [SPAN_W-1:0]  r_span;
    logic [TOTAL_W-1:0] r_rd_total, r_c1, r_c2, r_last_total, r_start_total;
    logic [TOTAL_W-1:0] r_mag, r_hi, r_lo, r_rem, r_q;
    logic               r_neg;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_valid, r_enough;
    logic [TOTAL_W-1:0] r_pulse;

    logic [AW-1:0]      rd_addr, last_c, prev_idx;
    logic [XW-1:0]      old_x, last_x, fm1_x;
    logic [TOTAL_W-1:0] snap_total, diff;
    logic [TOTAL_W:0]   mul_sum, div_rs;
    logic               div_ge, do_snap;

    // pointers
    assign last_c   = (r_wslot == '0) ? SLOT_MAX : r_wslot - 1'b1;
    assign last_x   = XW'(last_c);
    assign fm1_x    = XW'(r_fill - 1'b1);
    assign old_x    = (last_x >= fm1_x) ? last_x - fm1_x : last_x + XW'(RING_DEPTH) - fm1_x;
    assign prev_idx = (r_idx == '0) ? SLOT_MAX : r_idx - 1'b1;

    // widened count: tally * 32768 + raw
    assign snap_total = {{(TOTAL_W-TALLY_W-WIDEN_SH){r_tally[TALLY_W-1]}}, r_tally,
                         {WIDEN_SH{1'b0}}}
                      + {{(TOTAL_W-RAW_W){i_raw_count[RAW_W-1]}}, i_raw_count};

    assign do_snap = i_cmd.accept && (t_opcode'(i_opcode) == OP_SNAP);

    always_comb begin
        if (i_cmd.clamp) begin
            rd_addr = r_last;
        end else if (i_cmd.walk) begin
            rd_addr = prev_idx;
        end else begin
            rd_addr = r_oldest;
        end
    end

    // ring memories: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (do_snap) begin
            mem_time[r_wslot]  <= i_time_us;
            mem_total[r_wslot] <= snap_total;
        end
        r_rd_time  <= mem_time[rd_addr];
        r_rd_total <= mem_total[rd_addr];
    end

    // ring bookkeeping and tally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_fill  <= '0;
            r_tally <= '0;
        end else if (i_cmd.accept) begin
            case (i_opcode)
                OP_HIGH:  r_tally <= r_tally + 1'b1;
                OP_LOW:   r_tally <= r_tally - 1'b1;
                OP_SNAP: begin
                    r_wslot <= (r_wslot == SLOT_MAX) ? '0 : r_wslot + 1'b1;
                    if (r_fill != FILL_MAX) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                OP_CLEAR: begin
                    r_wslot <= '0;
                    r_fill  <= '0;
                    r_tally <= '0;
                end
                default: ;
            endcase
        end
    end

    assign diff    = r_c2 - r_c1;
    assign mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mag} : '0);
    assign div_rs  = {r_rem, r_hi[TOTAL_W-1]};
    assign div_ge  = (div_rs >= {1'b0, r_den});

    // query datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_now    <= i_time_us;
            r_span   <= SPAN_W'(i_window_ms) * SPAN_W'(MS_TO_US);
            r_last   <= last_c;
            r_oldest <= AW'(old_x);
        end
        if (i_cmd.calc_start) begin
            r_start <= (r_now >= TIME_W'(r_span)) ? r_now - TIME_W'(r_span) : '0;
        end
        if (i_cmd.clamp) begin
            if (r_start < r_rd_time) begin
                r_start <= r_rd_time;
            end
            r_start_total <= r_rd_total;
            r_idx         <= r_last;
            r_i           <= '0;
        end
        if (i_cmd.walk) begin
            if (r_i == '0) begin
                r_last_total <= r_rd_total;
            end
            if (o_stat.hit) begin
                if (r_i == '0) begin
                    r_start_total <= r_rd_total;
                end
                r_t1 <= r_rd_time;
                r_c1 <= r_rd_total;
            end else begin
                r_t2  <= r_rd_time;
                r_c2  <= r_rd_total;
                r_idx <= prev_idx;
                r_i   <= r_i + 1'b1;
            end
        end
        if (i_cmd.prep) begin
            r_start_total <= r_c1;
            r_den <= r_t2 - r_t1;
            r_neg <= diff[TOTAL_W-1];
            r_mag <= diff[TOTAL_W-1] ? '0 - diff : diff;
            r_hi  <= '0;
            r_lo  <= r_start - r_t1;
            r_cnt <= '0;
        end
        if (i_cmd.mul) begin
            r_hi  <= mul_sum[TOTAL_W:1];
            r_lo  <= {mul_sum[0], r_lo[TOTAL_W-1:1]};
            r_cnt <= o_stat.mul_done ? '0 : r_cnt + 1'b1;
            if (o_stat.mul_done) begin
                r_rem <= '0;
                r_q   <= '0;
            end
        end
        if (i_cmd.div) begin
            r_rem <= div_ge ? TOTAL_W'(div_rs - {1'b0, r_den}) : div_rs[TOTAL_W-1:0];
            r_hi  <= {r_hi[TOTAL_W-2:0], r_lo[TOTAL_W-1]};
            r_lo  <= {r_lo[TOTAL_W-2:0], 1'b0};
            r_q   <= {r_q[TOTAL_W-2:0], div_ge};
            r_cnt <= r_cnt + 1'b1;
            if (o_stat.div_done) begin
                r_start_total <= r_neg ? r_c1 - {r_q[TOTAL_W-2:0], div_ge}
                                       : r_c1 + {r_q[TOTAL_W-2:0], div_ge};
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.fin ||
                       (i_cmd.accept && (t_opcode'(i_opcode) == OP_QUERY) && !o_stat.fill_ok);
        end
        if (i_cmd.fin) begin
            r_pulse  <= r_last_total - r_start_total;
            r_enough <= 1'b1;
        end else begin
            r_pulse  <= '0;
            r_enough <= 1'b0;
        end
    end

    assign o_stat.fill_ok  = (r_fill >= FW'(2));
    assign o_stat.hit      = (r_rd_time <= r_start);
    assign o_stat.first    = (r_i == '0);
    assign o_stat.walk_end = (r_i == r_fill - 1'b1);
    assign o_stat.t_equal  = (r_t2 == r_t1);
    assign o_stat.mul_done = (r_cnt == MUL_LAST);
    assign o_stat.div_done = (r_cnt == DIV_LAST);

    assign o_valid       = r_valid;
    assign o_pulse_count = r_pulse;
    assign o_enough_data = r_enough;

endmodule

### rtl/windowed_pulse_count_meter.sv
`timescale 1ns / 1ps
// Events, snapshots and clear finish on acceptance; busy stays low and no result is sent.
// A query with fewer than two snapshots strobes its result in the cycle after start.
// Otherwise the sequencer computes and clamps the window start, then walks back over up
// to RING_DEPTH ring entries; interpolation adds a setup step (alone when timestamps are
// equal), then a shift-add multiply and a restoring divide. One item at a time; the
// result cannot be stalled. Synchronous active-low reset clears tally, pointers, strobe.
// ----------------------------------------------------------------------------
// windowed_pulse_count_meter: windowed pulse counter
// Tracks an overflow tally, stores timestamped counts, answers window queries.
// ----------------------------------------------------------------------------
module windowed_pulse_count_meter import wpcm_pkg::*; #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              i_opcode,
    input  logic [TIME_W-1:0]       i_time_us,
    input  logic signed [RAW_W-1:0] i_raw_count,
    input  logic [WIN_W-1:0]        i_window_ms,
    output logic                    o_valid,
    output logic [TOTAL_W-1:0]      o_pulse_count,
    output logic                    o_enough_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequence a query; everything else completes in the accept cycle
    wpcm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    // ring, tally and arithmetic
    wpcm_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_opcode),
        .i_time_us     (i_time_us),
        .i_raw_count   (i_raw_count),
        .i_window_ms   (i_window_ms),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_pulse_count (o_pulse_count),
        .o_enough_data (o_enough_data)
    );

    // a result goes out only once the sequencer has returned to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result strobe while busy");

    // a short-ring answer carries a zero count
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_enough_data) |-> (o_pulse_count == '0))
        else $error("nonzero count without enough data");

    // non-query items never produce a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode != OP_QUERY)) |=> !o_valid)
        else $error("result for non-query item");

endmodule
